@@ hdl/rpsag_pkg.sv @@
// ----------------------------------------------------------------------------
// rpsag_pkg: shared types and constants of the row segment address generator
// Register indexes, widths, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package rpsag_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int SEG_CNT_W    = $clog2(MAX_SEGMENTS + 1);

	localparam int ELEM_W       = 16;
	localparam int EB_W         = 5;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 3;
	localparam int ADDR_W       = 32;
	localparam int COUNT_W      = 20;
	localparam int PROD_W       = ELEM_W + EB_W;

	localparam int DIV_STEPS    = ELEM_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_PAGE_ELEMENTS  = 3'd0,
		CFG_ELEMENT_BYTES  = 3'd1,
		CFG_ROW_ELEMENTS   = 3'd2,
		CFG_SUBBLOCK_BYTES = 3'd3,
		CFG_PAGES_PER_ROW  = 3'd4
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic start;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic row_empty;
		logic seg_final;
		logic slot_free;
	} sts_t;

endpackage

@@ hdl/row_page_segment_address_generator_unit.sv @@
// ----------------------------------------------------------------------------
// row_page_segment_address_generator_unit: splits a tensor row into segments
// Flow: an accepted row first runs the 16-step subblock divider, then the
// walk yields one segment per cycle while the output slot is free. No new
// row is accepted until the walk of the current row is done.
// Reset: arst_n clears the controller, the result valid and the registers
// to their defaults (64, 2, 256, 64, 4).
// ----------------------------------------------------------------------------
module row_page_segment_address_generator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rpsag_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rpsag_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [rpsag_pkg::ELEM_W-1:0]        row_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rpsag_pkg::ADDR_W-1:0]        page_id,
	output logic [rpsag_pkg::ADDR_W-1:0]        byte_offset,
	output logic [rpsag_pkg::COUNT_W-1:0]       byte_count,
	output logic                                last_in_row,
	output logic                                overflow
);
	import rpsag_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rpsag_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rpsag_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.row_index   (row_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.page_id     (page_id),
		.byte_offset (byte_offset),
		.byte_count  (byte_count),
		.last_in_row (last_in_row),
		.overflow    (overflow)
	);

endmodule

@@ hdl/rpsag_div.sv @@
// ----------------------------------------------------------------------------
// rpsag_div: restoring divider, one quotient bit per cycle
// Divides the subblock byte size by the element size to get subblock elements.
// ----------------------------------------------------------------------------
module rpsag_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [rpsag_pkg::ELEM_W-1:0]   dividend,
	input  logic [rpsag_pkg::EB_W-1:0]     divisor,
	output logic                           done,
	output logic [rpsag_pkg::ELEM_W-1:0]   quotient
);
	import rpsag_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [EB_W-1:0]      rem_q;
	logic [ELEM_W-1:0]    quo_q;
	logic [EB_W:0]        shifted;
	logic [EB_W:0]        diff;
	logic                 fits;

	assign shifted = {rem_q, quo_q[ELEM_W-1]};
	assign diff    = shifted - {1'b0, divisor};
	assign fits    = shifted >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			// keep the partial remainder below the divisor
			rem_q <= fits ? diff[EB_W-1:0] : shifted[EB_W-1:0];
			quo_q <= {quo_q[ELEM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ hdl/rpsag_dp.sv @@
// ----------------------------------------------------------------------------
// rpsag_dp: datapath of the row segment address generator
// Holds the registers, walks the row one segment per command and drives
// the result register.
// ----------------------------------------------------------------------------
module rpsag_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  rpsag_pkg::cmd_t                     cmd,
	output rpsag_pkg::sts_t                     sts,
	input  logic                                cfg_we,
	input  logic [rpsag_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rpsag_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [rpsag_pkg::ELEM_W-1:0]        row_index,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [rpsag_pkg::ADDR_W-1:0]        page_id,
	output logic [rpsag_pkg::ADDR_W-1:0]        byte_offset,
	output logic [rpsag_pkg::COUNT_W-1:0]       byte_count,
	output logic                                last_in_row,
	output logic                                overflow
);
	import rpsag_pkg::*;

	// configuration
	logic [ELEM_W-1:0] pe_q;
	logic [EB_W-1:0]   eb_q;
	logic [ELEM_W-1:0] re_q;
	logic [ELEM_W-1:0] sb_q;
	logic [ELEM_W-1:0] ppr_q;

	// walk state
	logic [ELEM_W-1:0]    row_q;
	logic [ADDR_W-1:0]    base_q;
	logic [ELEM_W-1:0]    se_q;
	logic [ELEM_W-1:0]    col_q;
	logic [ELEM_W-1:0]    in_page_q;
	logic [ELEM_W-1:0]    page_q;
	logic [ADDR_W-1:0]    off_q;
	logic [SEG_CNT_W-1:0] seg_n_q;

	// result register
	logic                 out_valid_q;
	logic [ADDR_W-1:0]    page_id_q;
	logic [ADDR_W-1:0]    byte_offset_q;
	logic [COUNT_W-1:0]   byte_count_q;
	logic                 last_q;
	logic                 overflow_q;

	logic [ELEM_W-1:0]    pe_eff;
	logic [EB_W-1:0]      eb_eff;
	logic [ELEM_W-1:0]    pe_rem;
	logic [ELEM_W-1:0]    re_rem;
	logic [ELEM_W-1:0]    len_a;
	logic [ELEM_W-1:0]    len;
	logic                 page_done;
	logic                 row_done;
	logic [SEG_CNT_W-1:0] seg_n_next;
	logic                 cut;
	logic [PROD_W-1:0]    count_full;
	logic                 div_done;
	logic [ELEM_W-1:0]    quotient;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pe_q  <= 16'd64;
			eb_q  <= 5'd2;
			re_q  <= 16'd256;
			sb_q  <= 16'd64;
			ppr_q <= 16'd4;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_PAGE_ELEMENTS:  pe_q  <= cfg_data;
				CFG_ELEMENT_BYTES:  eb_q  <= cfg_data[EB_W-1:0];
				CFG_ROW_ELEMENTS:   re_q  <= cfg_data;
				CFG_SUBBLOCK_BYTES: sb_q  <= cfg_data;
				CFG_PAGES_PER_ROW:  ppr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pe_eff = (pe_q == '0) ? ELEM_W'(1) : pe_q;
	assign eb_eff = (eb_q == '0) ? EB_W'(1) : eb_q;

	rpsag_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.start),
		.dividend (sb_q),
		.divisor  (eb_eff),
		.done     (div_done),
		.quotient (quotient)
	);

	// segment length: first of page end, subblock end, row end
	assign pe_rem     = pe_eff - in_page_q;
	assign re_rem     = re_q - col_q;
	assign len_a      = (pe_rem < se_q) ? pe_rem : se_q;
	assign len        = (re_rem < len_a) ? re_rem : len_a;
	assign page_done  = (len == pe_rem);
	assign row_done   = (len == re_rem);
	assign seg_n_next = seg_n_q + 1'b1;
	assign cut        = !row_done && (seg_n_next == SEG_CNT_W'(MAX_SEGMENTS));
	assign count_full = PROD_W'(len) * PROD_W'(eb_eff);

	always_ff @(posedge clk) begin
		// page base settles during the divide
		base_q <= ADDR_W'(row_q) * ADDR_W'(ppr_q);
		if (cmd.start) begin
			row_q     <= row_index;
			col_q     <= '0;
			in_page_q <= '0;
			page_q    <= '0;
			off_q     <= '0;
			seg_n_q   <= '0;
		end else if (cmd.emit) begin
			col_q   <= col_q + len;
			seg_n_q <= seg_n_next;
			if (page_done) begin
				in_page_q <= '0;
				page_q    <= page_q + 1'b1;
				off_q     <= '0;
			end else begin
				in_page_q <= in_page_q + len;
				off_q     <= off_q + ADDR_W'(sb_q);
			end
		end
		if (div_done) begin
			se_q <= (quotient == '0) ? ELEM_W'(1) : quotient;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			page_id_q     <= base_q + ADDR_W'(page_q);
			byte_offset_q <= off_q;
			// saturate at the byte count field width
			byte_count_q  <= count_full[PROD_W-1:COUNT_W] != '0 ? '1 :
			                 count_full[COUNT_W-1:0];
			last_q        <= row_done;
			overflow_q    <= cut;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.row_empty = (re_q == '0);
	assign sts.seg_final = row_done || (seg_n_next == SEG_CNT_W'(MAX_SEGMENTS));
	assign sts.slot_free = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign page_id     = page_id_q;
	assign byte_offset = byte_offset_q;
	assign byte_count  = byte_count_q;
	assign last_in_row = last_q;
	assign overflow    = overflow_q;

endmodule

@@ hdl/rpsag_ctrl.sv @@
// ----------------------------------------------------------------------------
// rpsag_ctrl: controller of the row segment address generator
// Sequences accept, subblock divide and the per-segment walk.
// ----------------------------------------------------------------------------
module rpsag_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  rpsag_pkg::sts_t sts,
	output rpsag_pkg::cmd_t cmd
);
	import rpsag_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				// an empty row yields no item
				if (sts.div_done) state_d = sts.row_empty ? ST_IDLE : ST_RUN;
			end
			ST_RUN: begin
				if (sts.slot_free && sts.seg_final) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd.start = 1'b0;
		cmd.emit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_RUN: begin
				cmd.emit = sts.slot_free;
			end
			default: ;
		endcase
	end

endmodule

@@ verif/row_segment_checker.sv @@
// ----------------------------------------------------------------------------
// row_segment_checker: segment predictor and result comparison
// Tracks register writes, splits every accepted row into its page/subblock
// segments and compares each accepted result, field by field, in order.
// ----------------------------------------------------------------------------
module row_segment_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [rpsag_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rpsag_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [rpsag_pkg::ELEM_W-1:0]        row_index,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [rpsag_pkg::ADDR_W-1:0]        page_id,
	input  logic [rpsag_pkg::ADDR_W-1:0]        byte_offset,
	input  logic [rpsag_pkg::COUNT_W-1:0]       byte_count,
	input  logic                                last_in_row,
	input  logic                                overflow,
	output int                                  errors,
	output int                                  pending,
	output int                                  checked
);
	import rpsag_pkg::*;

	localparam logic [ELEM_W-1:0] DEF_PAGE_ELEMENTS  = 16'd64;
	localparam logic [EB_W-1:0]   DEF_ELEMENT_BYTES  = 5'd2;
	localparam logic [ELEM_W-1:0] DEF_ROW_ELEMENTS   = 16'd256;
	localparam logic [ELEM_W-1:0] DEF_SUBBLOCK_BYTES = 16'd64;
	localparam logic [ELEM_W-1:0] DEF_PAGES_PER_ROW  = 16'd4;
	localparam longint unsigned   BYTE_COUNT_LIMIT   = (64'd1 << COUNT_W) - 64'd1;

	typedef struct packed {
		logic [ADDR_W-1:0]  page_id;
		logic [ADDR_W-1:0]  byte_offset;
		logic [COUNT_W-1:0] byte_count;
		logic               last_in_row;
		logic               overflow;
	} segment_t;

	logic [ELEM_W-1:0] page_elems;
	logic [EB_W-1:0]   elem_bytes;
	logic [ELEM_W-1:0] row_elems;
	logic [ELEM_W-1:0] sub_bytes;
	logic [ELEM_W-1:0] row_pages;

	segment_t expected_segments[$];

	// Walk the row column by column; each segment stops at the nearest of
	// page end, subblock end and row end.
	function automatic void split_row(input logic [ELEM_W-1:0] row);
		longint unsigned pe, eb, se, re, col, in_page, page_end, sub_end, seg_end;
		longint unsigned pid, ofs, cnt;
		int n;
		segment_t seg;
		pe = (page_elems == '0) ? 64'd1 : 64'(page_elems);
		eb = (elem_bytes == '0) ? 64'd1 : 64'(elem_bytes);
		se = 64'(sub_bytes) / eb;
		if (se == 0)
			se = 1;
		re = 64'(row_elems);
		col = 0;
		n = 0;
		while (col < re && n < MAX_SEGMENTS) begin
			in_page = col % pe;
			page_end = col + (pe - in_page - 1);
			sub_end = col + se - 1;
			if (sub_end > re - 1)
				sub_end = re - 1;
			seg_end = (page_end < sub_end) ? page_end : sub_end;
			pid = 64'(row) * 64'(row_pages) + col / pe;
			ofs = (in_page / se) * 64'(sub_bytes);
			cnt = (seg_end - col + 1) * eb;
			if (cnt > BYTE_COUNT_LIMIT)
				cnt = BYTE_COUNT_LIMIT;
			seg.page_id = pid[ADDR_W-1:0];
			seg.byte_offset = ofs[ADDR_W-1:0];
			seg.byte_count = cnt[COUNT_W-1:0];
			col = seg_end + 1;
			n++;
			seg.last_in_row = (col >= re);
			seg.overflow = !seg.last_in_row && (n == MAX_SEGMENTS);
			expected_segments.push_back(seg);
		end
	endfunction

	function automatic int field_mismatch(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		segment_t want;
		int bad;
		bad = 0;
		if (!arst_n) begin
			page_elems <= DEF_PAGE_ELEMENTS;
			elem_bytes <= DEF_ELEMENT_BYTES;
			row_elems <= DEF_ROW_ELEMENTS;
			sub_bytes <= DEF_SUBBLOCK_BYTES;
			row_pages <= DEF_PAGES_PER_ROW;
			expected_segments.delete();
			errors <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// compare before pushing, a result never belongs to the row taken now
			if (out_valid && out_ready) begin
				if (expected_segments.size() == 0) begin
					$error("unexpected segment: page_id %0d byte_offset %0d byte_count %0d",
						page_id, byte_offset, byte_count);
					bad = 1;
				end else begin
					want = expected_segments.pop_front();
					bad = field_mismatch("page_id", want.page_id, page_id)
						+ field_mismatch("byte_offset", want.byte_offset, byte_offset)
						+ field_mismatch("byte_count", want.byte_count, byte_count)
						+ field_mismatch("last_in_row", want.last_in_row, last_in_row)
						+ field_mismatch("overflow", want.overflow, overflow);
					checked <= checked + 1;
				end
			end
			if (in_valid && in_ready)
				split_row(row_index);
			if (cfg_we) begin
				case (cfg_index)
					CFG_PAGE_ELEMENTS:  page_elems <= cfg_data;
					CFG_ELEMENT_BYTES:  elem_bytes <= cfg_data[EB_W-1:0];
					CFG_ROW_ELEMENTS:   row_elems <= cfg_data;
					CFG_SUBBLOCK_BYTES: sub_bytes <= cfg_data;
					CFG_PAGES_PER_ROW:  row_pages <= cfg_data;
					default: ;
				endcase
			end
			errors <= errors + bad;
			pending <= expected_segments.size();
		end
	end

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: row page/subblock segment address generator
// Directed rows on edge settings, then random settings and rows with random
// gaps on both channels, one long output stall and one full drain mid-run.
// ----------------------------------------------------------------------------
module testbench;
	import rpsag_pkg::*;

	localparam int SETTLE_CYCLES  = 200;
	localparam int RANDOM_PHASES  = 14;
	localparam int ROWS_PER_PHASE = 23;
	localparam int LONG_HOLD      = 400;
	localparam int HOLD_AFTER     = 400;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [ELEM_W-1:0]      row_index;
	logic                   out_valid;
	logic                   out_ready;
	logic [ADDR_W-1:0]      page_id;
	logic [ADDR_W-1:0]      byte_offset;
	logic [COUNT_W-1:0]     byte_count;
	logic                   last_in_row;
	logic                   overflow;

	int errors;
	int pending;
	int checked;
	int sent_rows = 0;
	int settings_loaded = 0;
	int results_taken = 0;
	bit sender_burst = 1'b0;
	bit sink_burst = 1'b0;
	bit hold_done = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	row_page_segment_address_generator_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.row_index   (row_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.page_id     (page_id),
		.byte_offset (byte_offset),
		.byte_count  (byte_count),
		.last_in_row (last_in_row),
		.overflow    (overflow)
	);

	row_segment_checker seg_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.row_index   (row_index),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.page_id     (page_id),
		.byte_offset (byte_offset),
		.byte_count  (byte_count),
		.last_in_row (last_in_row),
		.overflow    (overflow),
		.errors      (errors),
		.pending     (pending),
		.checked     (checked)
	);

	task automatic send_row(input logic [ELEM_W-1:0] row);
		int gap;
		gap = sender_burst ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		row_index <= row;
		do @(posedge clk); while (!(in_valid && in_ready));
		sent_rows++;
	endtask

	// Drop valid and hold until every predicted segment is back; optionally
	// let the block finish rows that produce nothing.
	task automatic wait_results(input bit settle);
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		if (settle)
			repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [ELEM_W-1:0] pe, input logic [EB_W-1:0] eb,
			input logic [ELEM_W-1:0] re, input logic [ELEM_W-1:0] sb,
			input logic [ELEM_W-1:0] ppr);
		wait_results(1'b1);
		write_reg(CFG_PAGE_ELEMENTS, pe);
		write_reg(CFG_ELEMENT_BYTES, {11'($urandom()), eb});
		write_reg(CFG_ROW_ELEMENTS, re);
		write_reg(CFG_SUBBLOCK_BYTES, sb);
		write_reg(CFG_PAGES_PER_ROW, ppr);
		// unused index, must leave every register alone
		write_reg(CFG_INDEX_W'(CFG_PAGES_PER_ROW) + CFG_INDEX_W'($urandom_range(1, 3)),
			16'($urandom()));
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	function automatic logic [ELEM_W-1:0] pick_size(input int small_max);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return ELEM_W'($urandom());
			default: return ELEM_W'($urandom_range(1, small_max));
		endcase
	endfunction

	initial begin : sink
		int w;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!hold_done && results_taken >= HOLD_AFTER && in_valid) begin
				// long stall while rows keep coming, to back up the input
				w = LONG_HOLD;
				hold_done = 1'b1;
			end else begin
				if ($urandom_range(0, 39) == 0)
					sink_burst = !sink_burst;
				w = sink_burst ? 0 : $urandom_range(0, 15);
			end
			if (w > 0) begin
				out_ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
			results_taken++;
		end
	end

	initial begin : stimulus
		logic [ELEM_W-1:0] pe, re, sb, ppr;
		logic [EB_W-1:0] eb;
		int rows;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		row_index <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// defaults after reset
		send_row('0);
		send_row('1);
		send_row(16'd1);
		// zero page size, zero element size, zero subblock
		load_settings('0, '0, 16'd5, '0, '1);
		send_row('1);
		send_row(16'h5555);
		// every size at its top
		load_settings('1, 5'd16, '1, '1, '1);
		send_row('1);
		send_row(16'hAAAA);
		// empty row: nothing comes out
		load_settings(16'd1000, 5'd3, '0, 16'd100, 16'd7);
		send_row(16'd3);
		send_row(16'd4);
		// subblock below one element, row cut after the segment limit
		load_settings(16'd10, 5'd16, 16'd1000, 16'd8, 16'd3);
		send_row(16'd2);
		send_row(16'd1);
		// row ends exactly on the last allowed segment
		load_settings(16'd64, 5'd1, 16'd64, 16'd1, 16'd1);
		send_row(16'd9);
		// pages not a multiple of subblocks
		load_settings(16'd48, 5'd4, 16'd200, 16'd100, 16'd2);
		send_row(16'd77);
		send_row(16'hFFFE);
		// element size beyond the nominal range
		load_settings('1, 5'd31, '1, '1, 16'd9);
		send_row(16'd12);

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pe = pick_size(48);
			re = pick_size(400);
			sb = pick_size(128);
			ppr = ELEM_W'($urandom());
			case ($urandom_range(0, 9))
				0: eb = '0;
				1: eb = EB_W'($urandom_range(17, 31));
				2: eb = 5'd16;
				default: eb = EB_W'($urandom_range(1, 8));
			endcase
			load_settings(pe, eb, re, sb, ppr);
			sender_burst = ($urandom_range(0, 3) == 0);
			rows = (re == '0) ? 3 : ROWS_PER_PHASE;
			for (int i = 0; i < rows; i++) begin
				if (phase == RANDOM_PHASES / 2 && i == 10)
					wait_results(1'b0);
				if ($urandom_range(0, 15) == 0)
					send_row(($urandom_range(0, 1) == 0) ? '0 : '1);
				else
					send_row(ELEM_W'($urandom()));
			end
		end

		wait_results(1'b1);
		$display("Covered %0d rows under %0d register settings, %0d segments checked",
			sent_rows, settings_loaded, checked);
		if (errors == 0)
			$display("PASS row_page_segment_address_generator_unit");
		else
			$display("FAIL row_page_segment_address_generator_unit");
		$finish;
	end

	initial begin : watchdog
		#40_000_000;
		$display("FAIL row_page_segment_address_generator_unit");
		$finish;
	end

endmodule
